// ----- sv/stb_pkg.sv -----
// ----------------------------------------------------------------------------
// stb_pkg
// shared types and constants for the software timer bank
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int unsigned NUM_TIMERS_DEF = 16;
  localparam int unsigned FINE_DIV       = 100;
  localparam int unsigned RES_W          = $clog2(FINE_DIV);
  localparam int unsigned CNT_W          = 16;

  typedef enum logic [2:0] {
    CMD_FINE_TICK = 3'd0,
    CMD_ADD_TICKS = 3'd1,
    CMD_START     = 3'd2,
    CMD_STOP      = 3'd3,
    CMD_RESTART   = 3'd4,
    CMD_QUERY     = 3'd5,
    CMD_MASK_STOP = 3'd6,
    CMD_ELAPSED   = 3'd7
  } stb_cmd_t;

  // counter values after one request
  typedef struct packed {
    logic [CNT_W-1:0] fine;
    logic [CNT_W-1:0] coarse;
  } stb_count_t;

  // timer store operations for one request
  typedef struct packed {
    logic start;      // write period and mark, set enable
    logic restart;    // write mark only
    logic stop;       // clear one enable
    logic mask_stop;  // clear enables under the mask
    logic read;       // fetch mark, period and enable
  } stb_op_t;

endpackage

// ----- sv/software_timer_bank_unit.sv -----
// ----------------------------------------------------------------------------
// software_timer_bank_unit
// bank of timeout timers sharing a fine/coarse tick counter
// ----------------------------------------------------------------------------
// Takes one request per clock while the output is not stalled and returns one
// result per request via the stage 1 and output registers. Throughput is
// set by the single read port of the mark/period memories: each request
// reads at most one timer entry, which is registered and then compared in
// the second stage. Start and restart write the memories at acceptance, so a
// query of the same timer in the next request already sees the new entry.
// The output register lets a new request enter while a result waits.
// ----------------------------------------------------------------------------
module software_timer_bank_unit
  import stb_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [3:0]  timer_index,
  input  logic [15:0] value,
  input  logic [15:0] stop_mask,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        expired,
  output logic [15:0] coarse_count,
  output logic [15:0] fine_count,
  output logic [15:0] elapsed
);

  localparam int unsigned AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // request handshake
  logic       accept;
  stb_cmd_t   in_cmd;
  logic       in_range;
  logic [AW-1:0] addr;

  // stage 1: memory read in flight
  logic             s1_valid;
  stb_cmd_t         s1_cmd;
  logic [CNT_W-1:0] s1_value;
  stb_count_t       s1_count;
  logic             s1_advance;

  stb_count_t       count_next;
  stb_op_t          op;
  logic [CNT_W-1:0] rd_mark;
  logic [CNT_W-1:0] rd_period;
  logic             rd_enabled;

  // stage 2 result
  logic             hit;
  logic [CNT_W-1:0] diff;
  logic [CNT_W-1:0] base;

  assign in_cmd   = stb_cmd_t'(cmd);
  assign in_range = 32'(timer_index) < NUM_TIMERS;
  assign addr     = AW'(timer_index);

  // stage 1 moves on once the output register is free or being drained
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;
  assign accept     = in_valid && in_ready;

  // decode timer operations
  always_comb begin
    op           = '0;
    op.start     = accept && (in_cmd == CMD_START);
    op.restart   = accept && (in_cmd == CMD_RESTART);
    op.stop      = accept && (in_cmd == CMD_STOP);
    op.mask_stop = accept && (in_cmd == CMD_MASK_STOP);
    op.read      = accept && (in_cmd == CMD_QUERY);
  end

  stb_tick_counter u_counter (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .cmd        (in_cmd),
    .value      (value),
    .count_next (count_next)
  );

  // start and restart take the coarse count as it stands before this request,
  // which is unchanged by those commands
  stb_timer_store #(
    .NUM_TIMERS (NUM_TIMERS),
    .AW         (AW)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .addr       (addr),
    .in_range   (in_range),
    .period_in  (value),
    .mark_in    (count_next.coarse),
    .stop_mask  (stop_mask),
    .rd_mark    (rd_mark),
    .rd_period  (rd_period),
    .rd_enabled (rd_enabled)
  );

  // one shared subtractor: elapsed from a given mark or from a timer start
  assign base = (s1_cmd == CMD_ELAPSED) ? s1_value : rd_mark;
  assign diff = s1_count.coarse - base;
  assign hit  = (s1_cmd == CMD_QUERY) && rd_enabled;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd   <= in_cmd;
      s1_value <= value;
      s1_count <= count_next;
    end
    if (s1_advance) begin
      coarse_count <= s1_count.coarse;
      fine_count   <= s1_count.fine;
      // stopped or out-of-range timers answer zero
      expired      <= hit && (diff > rd_period);
      elapsed      <= ((s1_cmd == CMD_ELAPSED) || hit) ? diff : '0;
    end
  end

endmodule

// ----- sv/stb_tick_counter.sv -----
// ----------------------------------------------------------------------------
// stb_tick_counter
// fine and coarse tick counters, coarse steps every hundredth fine tick and on added ticks
// ----------------------------------------------------------------------------
module stb_tick_counter
  import stb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  stb_cmd_t         cmd,
  input  logic [CNT_W-1:0] value,
  output stb_count_t       count_next
);

  logic [CNT_W-1:0] fine;
  logic [CNT_W-1:0] coarse;
  logic [RES_W-1:0] res;       // fine mod 100
  logic [RES_W-1:0] res_next;

  always_comb begin
    count_next.fine   = fine;
    count_next.coarse = coarse;
    res_next          = res;
    case (cmd)
      CMD_FINE_TICK: begin
        count_next.fine = fine + 1'b1;
        // 65535 wraps to 0, which is a multiple of the divider
        if (fine == {CNT_W{1'b1}} || res == RES_W'(FINE_DIV - 1)) begin
          res_next = '0;
        end else begin
          res_next = res + 1'b1;
        end
        if (res_next == '0) begin
          count_next.coarse = coarse + 1'b1;
        end
      end
      CMD_ADD_TICKS: begin
        count_next.coarse = coarse + value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fine   <= '0;
      coarse <= '0;
      res    <= '0;
    end else if (step) begin
      fine   <= count_next.fine;
      coarse <= count_next.coarse;
      res    <= res_next;
    end
  end

endmodule

// ----- sv/stb_timer_store.sv -----
// ----------------------------------------------------------------------------
// stb_timer_store
// start mark and period memories plus per-timer enable bits
// ----------------------------------------------------------------------------
module stb_timer_store
  import stb_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = NUM_TIMERS_DEF,
  parameter int unsigned AW         = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  stb_op_t               op,
  input  logic [AW-1:0]         addr,
  input  logic                  in_range,
  input  logic [CNT_W-1:0]      period_in,
  input  logic [CNT_W-1:0]      mark_in,
  input  logic [CNT_W-1:0]      stop_mask,
  output logic [CNT_W-1:0]      rd_mark,
  output logic [CNT_W-1:0]      rd_period,
  output logic                  rd_enabled
);

  logic [CNT_W-1:0]      mark_mem   [NUM_TIMERS];
  logic [CNT_W-1:0]      period_mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] enabled;
  logic [NUM_TIMERS-1:0] mask_ext;

  // mask bits beyond the bank drop out, timers beyond bit 15 see zero
  assign mask_ext = NUM_TIMERS'(stop_mask);

  // memories
  always_ff @(posedge clk) begin
    if (in_range && (op.start || op.restart)) begin
      mark_mem[addr] <= mark_in;
    end
    if (in_range && op.start) begin
      period_mem[addr] <= period_in;
    end
    if (op.read) begin
      rd_mark   <= mark_mem[addr];
      rd_period <= period_mem[addr];
    end
  end

  // enable bits
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled    <= '0;
      rd_enabled <= 1'b0;
    end else begin
      if (op.read) begin
        rd_enabled <= in_range && enabled[addr];
      end
      if (op.mask_stop) begin
        enabled <= enabled & ~mask_ext;
      end else if (in_range && op.start) begin
        enabled[addr] <= 1'b1;
      end else if (in_range && op.stop) begin
        enabled[addr] <= 1'b0;
      end
    end
  end

endmodule
